### rtl/core/lfd_pkg.sv
// Shared constants and control types for the fractional delay line.
package lfd_pkg;

   localparam int WEIGHT_BITS  = 28;
   localparam int CHUNK_BITS   = 24;
   localparam int RESET_POINTS = 5;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_BUFFER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DELAY_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_INTERP_POINTS = 2'd2;

   typedef struct packed {
      logic load;
      logic prep;
      logic diff;
      logic tgt;
      logic back;
      logic rd;
      logic nskip;
      logic nsel;
      logic chunk;
      logic rnd;
      logic dinit;
      logic dstep;
      logic mac1;
      logic mac2;
      logic fin;
   } lfd_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic n_end;
      logic n_skip;
      logic tap_last;
      logic out_free;
   } lfd_status_type;

endpackage

### rtl/core/lfd_channels.sv
// Valid/ready channel interfaces for the sample input and the delayed output.
interface lfd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface lfd_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] delayed_out;
   modport source (output valid, output delayed_out, input ready);
   modport sink (input valid, input delayed_out, output ready);
endinterface

### rtl/core/lfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lfd_ctrl.sv
// Sequencer for one sample: read point, tap gather, weight build, divide, accumulate.
module lfd_ctrl import lfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  lfd_status_type stat,
   output lfd_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PREP  = 4'd1;
   localparam logic [3:0] ST_DIFF  = 4'd2;
   localparam logic [3:0] ST_TGT   = 4'd3;
   localparam logic [3:0] ST_BACK  = 4'd4;
   localparam logic [3:0] ST_RD    = 4'd5;
   localparam logic [3:0] ST_NSEL  = 4'd6;
   localparam logic [3:0] ST_CHUNK = 4'd7;
   localparam logic [3:0] ST_RND   = 4'd8;
   localparam logic [3:0] ST_DINIT = 4'd9;
   localparam logic [3:0] ST_DSTEP = 4'd10;
   localparam logic [3:0] ST_MAC1  = 4'd11;
   localparam logic [3:0] ST_MAC2  = 4'd12;
   localparam logic [3:0] ST_FIN   = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_TGT;
         end
         ST_TGT: begin
            cmd.tgt  = 1'b1;
            state_in = ST_BACK;
         end
         ST_BACK: begin
            if (stat.cnt_zero) begin
               state_in = ST_RD;
            end else begin
               cmd.back = 1'b1;
            end
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_NSEL;
         end
         ST_NSEL: begin
            if (stat.n_end) begin
               state_in = ST_DINIT;
            end else if (stat.n_skip) begin
               cmd.nskip = 1'b1;
            end else begin
               cmd.nsel = 1'b1;
               state_in = ST_CHUNK;
            end
         end
         ST_CHUNK: begin
            cmd.chunk = 1'b1;
            if (stat.cnt_zero) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_NSEL;
         end
         ST_DINIT: begin
            cmd.dinit = 1'b1;
            state_in  = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.dstep = 1'b1;
            if (stat.cnt_zero) begin
               state_in = ST_MAC1;
            end
         end
         ST_MAC1: begin
            cmd.mac1 = 1'b1;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            cmd.mac2 = 1'b1;
            state_in = stat.tap_last ? ST_FIN : ST_RD;
         end
         ST_FIN: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign in_ready = (state_ff == ST_IDLE);

endmodule

### rtl/core/lfd_dp.sv
// Datapath: settings, sample store, read point, Lagrange weights, divider, accumulator.
module lfd_dp import lfd_pkg::*; #(
   parameter int DEPTH       = 4096,
   parameter int MAX_POINTS  = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16,
   localparam int CSR_BITS   = $clog2(DEPTH) + FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfd_cmd_type                   cmd,
   output lfd_status_type                stat,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_BITS-1:0]           csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int AW       = $clog2(DEPTH);
   localparam int LEN_BITS = AW + 1;
   localparam int DLY_BITS = CSR_BITS;
   localparam int PL       = $clog2(MAX_POINTS);
   localparam int PTS_BITS = (PL + 1 > 4) ? PL + 1 : 4;
   localparam int M_BITS   = WEIGHT_BITS + (MAX_POINTS - 1) * PL + 4;
   localparam int NCH      = (M_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int MS_BITS  = NCH * CHUNK_BITS;
   localparam int T_BITS   = FRAC_BITS + PL;
   localparam int P_BITS   = MS_BITS + T_BITS;
   localparam int D_BITS   = (MAX_POINTS - 1) * PL;
   localparam int R_BITS   = D_BITS + 1;
   localparam int N_BITS   = M_BITS + 1;
   localparam int W_BITS   = WEIGHT_BITS + 4;
   localparam int X_BITS   = PTS_BITS + FRAC_BITS;
   localparam int MP_BITS  = W_BITS + 1 + SAMPLE_BITS;
   localparam int ACC_BITS = MP_BITS + PL;
   localparam int RES_BITS = ACC_BITS - WEIGHT_BITS;
   localparam int CNT_BITS = $clog2(N_BITS + 1);

   // settings
   logic [LEN_BITS-1:0] len_cfg_ff;
   logic [DLY_BITS-1:0] dly_cfg_ff;
   logic [PTS_BITS-1:0] pts_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= LEN_BITS'(DEPTH);
         dly_cfg_ff <= '0;
         pts_cfg_ff <= PTS_BITS'(RESET_POINTS);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BUFFER_LENGTH: len_cfg_ff <= csr_wdata[LEN_BITS-1:0];
            REG_DELAY_LENGTH:  dly_cfg_ff <= csr_wdata;
            REG_INTERP_POINTS: pts_cfg_ff <= csr_wdata[PTS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-item state
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic [LEN_BITS-1:0]           len_ff;
   logic [PTS_BITS-1:0]           pts_ff;
   logic [PTS_BITS-1:0]           s0_ff;
   logic [DLY_BITS-1:0]           d_ff;
   logic [DLY_BITS:0]             diff_ff;
   logic [AW-1:0]                 idx_ff;
   logic [X_BITS-1:0]             x_ff;
   logic [CNT_BITS-1:0]           cnt_ff;
   logic [PTS_BITS-1:0]           k_ff;
   logic [PTS_BITS-1:0]           n_ff;
   logic [MS_BITS-1:0]            m_ff;
   logic [P_BITS-1:0]             prod_ff;
   logic [T_BITS-1:0]             t_ff;
   logic [D_BITS-1:0]             den_ff;
   logic                          neg_ff;
   logic                          tap_ok_ff;
   logic [R_BITS-1:0]             rem_ff;
   logic [N_BITS-1:0]             dvd_ff;
   logic signed [MP_BITS-1:0]     mp_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic [AW-1:0]                 wp_ff;
   logic [LEN_BITS-1:0]           fill_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic [LEN_BITS-1:0]           len_in;
   logic [PTS_BITS-1:0]           pts_in;
   logic [LEN_BITS-1:0]           len_m1;
   logic [DLY_BITS-1:0]           dmax;
   logic [DLY_BITS:0]             tsum;
   logic [AW-1:0]                 idx_dec;
   logic [AW-1:0]                 idx_inc;
   logic [LEN_BITS-1:0]           idx_p1;
   logic signed [X_BITS:0]        dx;
   logic [PTS_BITS-1:0]           fac;
   logic [R_BITS:0]               r2;
   logic                          ge;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] tapv;
   logic signed [MP_BITS-1:0]     mp_in;
   logic signed [ACC_BITS-1:0]    fin_sum;
   logic signed [RES_BITS-1:0]    res;
   logic signed [SAMPLE_BITS-1:0] sat;
   logic [LEN_BITS-1:0]           wp_p1;

   always_comb begin
      if (len_cfg_ff < LEN_BITS'(2)) begin
         len_in = LEN_BITS'(2);
      end else if (len_cfg_ff > LEN_BITS'(DEPTH)) begin
         len_in = LEN_BITS'(DEPTH);
      end else begin
         len_in = len_cfg_ff;
      end
      if (pts_cfg_ff == '0) begin
         pts_in = PTS_BITS'(1);
      end else if (pts_cfg_ff > PTS_BITS'(MAX_POINTS)) begin
         pts_in = PTS_BITS'(MAX_POINTS);
      end else begin
         pts_in = pts_cfg_ff;
      end
   end

   assign len_m1  = len_ff - LEN_BITS'(1);
   assign dmax    = {len_m1[AW-1:0], {FRAC_BITS{1'b0}}};
   assign tsum    = diff_ff[DLY_BITS] ? diff_ff + {len_ff, {FRAC_BITS{1'b0}}} : diff_ff;
   assign idx_dec = (idx_ff == '0) ? len_m1[AW-1:0] : idx_ff - AW'(1);
   assign idx_p1  = {1'b0, idx_ff} + LEN_BITS'(1);
   assign idx_inc = (idx_p1 == len_ff) ? '0 : idx_p1[AW-1:0];
   assign dx      = $signed({1'b0, x_ff}) - $signed({1'b0, n_ff, {FRAC_BITS{1'b0}}});
   assign fac     = (n_ff < k_ff) ? n_ff + PTS_BITS'(1) : n_ff - k_ff;
   assign r2      = {rem_ff, dvd_ff[N_BITS-1]};
   assign ge      = (r2 >= {2'b00, den_ff});
   assign tapv    = tap_ok_ff ? $signed(rd_data) : '0;
   assign mp_in   = $signed({1'b0, dvd_ff[W_BITS-1:0]}) * tapv;
   assign fin_sum = acc_ff + (ACC_BITS'(1) <<< (WEIGHT_BITS - 1));
   assign res     = fin_sum[ACC_BITS-1:WEIGHT_BITS];
   assign wp_p1   = {1'b0, wp_ff} + LEN_BITS'(1);

   // round half up after the product: add one half before the fraction bits are dropped
   logic [P_BITS-1:0] rnd_val;
   assign rnd_val = prod_ff + (P_BITS'(1) << (FRAC_BITS - 1));

   always_comb begin
      if (res[RES_BITS-1:SAMPLE_BITS-1] == '0 || res[RES_BITS-1:SAMPLE_BITS-1] == '1) begin
         sat = res[SAMPLE_BITS-1:0];
      end else if (res[RES_BITS-1]) begin
         sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff <= in_sample;
         len_ff <= len_in;
         pts_ff <= pts_in;
         acc_ff <= '0;
         k_ff   <= '0;
      end
      if (cmd.prep) begin
         d_ff  <= (dly_cfg_ff > dmax) ? dmax : dly_cfg_ff;
         s0_ff <= (pts_ff - PTS_BITS'(1)) >> 1;
      end
      if (cmd.diff) begin
         diff_ff <= {1'b0, wp_ff, {FRAC_BITS{1'b0}}} - {1'b0, d_ff};
      end
      if (cmd.tgt) begin
         idx_ff <= tsum[DLY_BITS-1:FRAC_BITS];
         x_ff   <= {s0_ff, tsum[FRAC_BITS-1:0]};
         cnt_ff <= CNT_BITS'(s0_ff);
      end
      if (cmd.back) begin
         idx_ff <= idx_dec;
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.rd) begin
         tap_ok_ff <= ({1'b0, idx_ff} < fill_ff);
         m_ff      <= MS_BITS'(1) << WEIGHT_BITS;
         den_ff    <= D_BITS'(1);
         neg_ff    <= ~(pts_ff[0] ^ k_ff[0]);
         n_ff      <= '0;
      end
      if (cmd.nskip) begin
         n_ff <= n_ff + PTS_BITS'(1);
      end
      if (cmd.nsel) begin
         t_ff    <= dx[X_BITS] ? T_BITS'(-dx) : T_BITS'(dx);
         neg_ff  <= neg_ff ^ dx[X_BITS];
         den_ff  <= D_BITS'(den_ff * fac);
         prod_ff <= '0;
         cnt_ff  <= CNT_BITS'(NCH - 1);
      end
      if (cmd.chunk) begin
         // most significant chunk first: shift the partial sum up each step
         prod_ff <= P_BITS'({prod_ff, {CHUNK_BITS{1'b0}}})
                    + P_BITS'(m_ff[MS_BITS-1 -: CHUNK_BITS] * t_ff);
         m_ff    <= m_ff << CHUNK_BITS;
         cnt_ff  <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.rnd) begin
         m_ff <= MS_BITS'(rnd_val[FRAC_BITS + M_BITS - 1:FRAC_BITS]);
         n_ff <= n_ff + PTS_BITS'(1);
      end
      if (cmd.dinit) begin
         dvd_ff <= N_BITS'(m_ff[M_BITS-1:0]) + N_BITS'(den_ff >> 1);
         rem_ff <= '0;
         cnt_ff <= CNT_BITS'(N_BITS - 1);
      end
      if (cmd.dstep) begin
         rem_ff <= ge ? R_BITS'(r2 - {2'b00, den_ff}) : R_BITS'(r2);
         dvd_ff <= {dvd_ff[N_BITS-2:0], ge};
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.mac1) begin
         mp_ff <= mp_in;
      end
      if (cmd.mac2) begin
         acc_ff <= neg_ff ? acc_ff - ACC_BITS'(mp_ff) : acc_ff + ACC_BITS'(mp_ff);
         k_ff   <= k_ff + PTS_BITS'(1);
         idx_ff <= idx_inc;
      end
      if (cmd.fin) begin
         out_ff <= sat;
      end
   end

   // write position, fill mark and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.prep && ({1'b0, wp_ff} >= len_ff)) begin
            wp_ff <= '0;
         end
         if (cmd.fin) begin
            wp_ff <= (wp_p1 == len_ff) ? '0 : wp_p1[AW-1:0];
            if ({1'b0, wp_ff} >= fill_ff) begin
               fill_ff <= wp_p1;
            end
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   lfd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.fin),
      .wr_addr (wp_ff),
      .wr_data (smp_ff),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign stat.cnt_zero = (cnt_ff == '0);
   assign stat.n_end    = (n_ff == pts_ff);
   assign stat.n_skip   = (n_ff == k_ff);
   assign stat.tap_last = (k_ff == pts_ff - PTS_BITS'(1));
   assign stat.out_free = ~out_valid_ff | out_ready;

   assign out_valid  = out_valid_ff;
   assign out_sample = out_ff;

endmodule

### rtl/core/lagrange_fractional_delay_line.sv
// Top level of the Lagrange-interpolated fractional delay line.
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    sample_in   (signed, SAMPLE_BITS)
//   rsp_ch    out   valid/ready    delayed_out (signed, SAMPLE_BITS)
//   csr_*     in    csr_wr_en      csr_index, csr_wdata
//
// For N taps, the read point is first stepped back s0 = (N-1)/2 entries; N_BITS = 54 and
// NCH = 3 at the default sizes. The one-bit-per-cycle weight divider works through N_BITS
// quotient bits per weight, and the chunked weight multiplier through NCH chunks per factor.
// Synchronous reset; the sample store needs no clearing pass, unwritten entries are masked to 0 by the fill mark.
// A new sample is taken while a finished result waits on rsp_ch; the next result holds
// until that one is transferred.
module lagrange_fractional_delay_line import lfd_pkg::*; #(
   parameter int DEPTH       = 4096,
   parameter int MAX_POINTS  = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16,
   localparam int CSR_BITS   = $clog2(DEPTH) + FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   lfd_req_if.sink                 req_ch,
   lfd_rsp_if.source               rsp_ch,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   lfd_cmd_type    cmd;
   lfd_status_type stat;

   lfd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   lfd_dp #(
      .DEPTH       (DEPTH),
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_sample  (req_ch.sample_in),
      .out_ready  (rsp_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_sample (rsp_ch.delayed_out)
   );

`ifndef SYNTHESIS
   // one sample at a time: a transfer in closes the input for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input open right after a transfer");

   // a fresh result appears as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> req_ch.ready)
      else $error("result raised while busy");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");
`endif

endmodule
